[rtl/core/csp_pkg.sv]
// Package for the CIGAR string parser: character codes, BAM operation codes,
// field widths and the state and result structures shared by the RTL.
// No dependencies.
package csp_pkg;

    // Field widths
    localparam int unsigned COUNT_W = 28;
    localparam int unsigned COVER_W = 32;
    localparam int unsigned CODE_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [COVER_W-1:0] COVER_MAX     = {COVER_W{1'b1}};
    localparam logic [COUNT_W-1:0] CLIP_THR_INIT = 28'd10;

    // ASCII codes of the characters that mean something
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_X    = 8'h58;

    // BAM operation codes
    localparam logic [CODE_W-1:0] OP_M  = 4'd0;
    localparam logic [CODE_W-1:0] OP_I  = 4'd1;
    localparam logic [CODE_W-1:0] OP_D  = 4'd2;
    localparam logic [CODE_W-1:0] OP_N  = 4'd3;
    localparam logic [CODE_W-1:0] OP_S  = 4'd4;
    localparam logic [CODE_W-1:0] OP_H  = 4'd5;
    localparam logic [CODE_W-1:0] OP_P  = 4'd6;
    localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [CODE_W-1:0] OP_X  = 4'd8;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } op_dec_t;

    // Per-string parser state
    typedef struct packed {
        logic [COUNT_W-1:0] digit_accum;
        logic [COVER_W-1:0] cover_accum;
        logic               seen_op;
        logic               first_clip_long;
        logic               recent_clip_long;
    } parse_state_t;

    // One result beat
    typedef struct packed {
        logic               op_valid;
        logic [CODE_W-1:0]  op_code;
        logic [COUNT_W-1:0] op_length;
        logic               string_done;
        logic [COVER_W-1:0] covered_length;
        logic               left_long_clip;
        logic               right_long_clip;
    } result_t;

    // Map an operation letter to its BAM code.
    function automatic op_dec_t decode_op(input logic [7:0] ch);
        op_dec_t d;
        d.hit  = 1'b1;
        d.code = OP_M;
        unique case (ch)
            CH_M:    d.code = OP_M;
            CH_I:    d.code = OP_I;
            CH_D:    d.code = OP_D;
            CH_N:    d.code = OP_N;
            CH_S:    d.code = OP_S;
            CH_H:    d.code = OP_H;
            CH_P:    d.code = OP_P;
            CH_EQ:   d.code = OP_EQ;
            CH_X:    d.code = OP_X;
            default: d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/cigar_string_parser_top.sv]
// Top level of the CIGAR string parser: handshakes, parser state, threshold
// register and the output register with its skid stage.
// Depends on csp_pkg and csp_update.

// The parser takes one character per cycle and gives at most one result beat
// per character, through the registered output stage. An operation letter
// gives its BAM code and the count before it; the last character of a string
// also carries the covered reference length and the two long soft clip flags.
// Throughput is one character per clock while the output side keeps up; the
// whole update is a single registered step, a shift-add of the count and a
// 32-bit add of the covered length. A two-entry output stage (result register
// plus skid register) lets input keep flowing while the output stalls;
// in_stall rises only when both entries hold results. clip_threshold may only
// be written while no string is in flight and no result waits.
module cigar_string_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [csp_pkg::COUNT_W-1:0]   cfg_wr_data,
    // Character input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    char_byte,
    input  logic                          is_last,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          op_valid,
    output logic [csp_pkg::CODE_W-1:0]    op_code,
    output logic [csp_pkg::COUNT_W-1:0]   op_length,
    output logic                          string_done,
    output logic [csp_pkg::COVER_W-1:0]   covered_length,
    output logic                          left_long_clip,
    output logic                          right_long_clip
);
    import csp_pkg::*;

    logic [COUNT_W-1:0] clip_thr_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    result_t            new_result;
    logic               emit;
    logic               in_accept;
    logic               out_pop;
    result_t            out_data_reg;
    logic               out_valid_reg;
    result_t            skid_data_reg;
    logic               skid_valid_reg;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_pop   = out_valid_reg && !out_stall;

    // Character update logic
    csp_update u_update (
        .state          (state_reg),
        .char_byte      (char_byte),
        .is_last        (is_last),
        .clip_threshold (clip_thr_reg),
        .state_next     (state_next),
        .result         (new_result),
        .emit           (emit)
    );

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_thr_reg <= CLIP_THR_INIT;
        end
        else if (cfg_wr_en)
        begin
            clip_thr_reg <= cfg_wr_data;
        end
    end

    // Parser state advances on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept && emit;
            end
        end
        else if (in_accept && emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : new_result;
        end
        else if (in_accept && emit)
        begin
            skid_data_reg <= new_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign op_valid        = out_data_reg.op_valid;
    assign op_code         = out_data_reg.op_code;
    assign op_length       = out_data_reg.op_length;
    assign string_done     = out_data_reg.string_done;
    assign covered_length  = out_data_reg.covered_length;
    assign left_long_clip  = out_data_reg.left_long_clip;
    assign right_long_clip = out_data_reg.right_long_clip;

endmodule

[rtl/core/csp_update.sv]
// Next-state and result logic for one CIGAR character.
// Depends on csp_pkg for the state and result structures and the code tables.
module csp_update (
    input  csp_pkg::parse_state_t          state,
    input  logic [7:0]                     char_byte,
    input  logic                           is_last,
    input  logic [csp_pkg::COUNT_W-1:0]    clip_threshold,
    output csp_pkg::parse_state_t          state_next,
    output csp_pkg::result_t               result,
    output logic                           emit
);
    import csp_pkg::*;

    op_dec_t            dec;
    logic               is_digit;
    logic [3:0]         digit_val;
    logic [COVER_W-1:0] times_ten;
    logic [COVER_W-1:0] digit_sum;
    logic               covers_ref;
    logic               long_clip;
    logic [COVER_W:0]   cover_sum;
    logic [COVER_W-1:0] cover_sat;
    parse_state_t       upd;

    // Decimal count: acc * 10 + digit fits in 32 bits, then saturate to 28
    assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit_val = 4'(char_byte - CH_ZERO);
    assign times_ten = ({{(COVER_W-COUNT_W){1'b0}}, state.digit_accum} << 3)
                     + ({{(COVER_W-COUNT_W){1'b0}}, state.digit_accum} << 1);
    assign digit_sum = times_ten + {{(COVER_W-4){1'b0}}, digit_val};

    // Operation decode and the reference span sum
    assign dec        = decode_op(char_byte);
    assign covers_ref = (dec.code == OP_M) || (dec.code == OP_D) || (dec.code == OP_N)
                     || (dec.code == OP_EQ) || (dec.code == OP_X);
    assign long_clip  = (dec.code == OP_S) && (state.digit_accum >= clip_threshold);
    assign cover_sum  = {1'b0, state.cover_accum}
                      + {{(COVER_W+1-COUNT_W){1'b0}}, state.digit_accum};
    assign cover_sat  = cover_sum[COVER_W] ? COVER_MAX : cover_sum[COVER_W-1:0];

    // State after this character, before any end-of-string clear
    always_comb
    begin
        upd = state;
        if (is_digit)
        begin
            upd.digit_accum = (digit_sum > {{(COVER_W-COUNT_W){1'b0}}, COUNT_MAX})
                            ? COUNT_MAX : digit_sum[COUNT_W-1:0];
        end
        else if (dec.hit)
        begin
            if (covers_ref)
            begin
                upd.cover_accum = cover_sat;
            end
            if (!state.seen_op)
            begin
                upd.first_clip_long = long_clip;
                upd.seen_op         = 1'b1;
            end
            upd.recent_clip_long = long_clip;
            upd.digit_accum      = '0;
        end
    end

    // Result beat and the cleared state at the end of a string
    always_comb
    begin
        result = '0;
        if (dec.hit && !is_digit)
        begin
            result.op_valid  = 1'b1;
            result.op_code   = dec.code;
            result.op_length = state.digit_accum;
        end
        if (is_last)
        begin
            result.string_done     = 1'b1;
            result.covered_length  = upd.cover_accum;
            result.left_long_clip  = upd.first_clip_long;
            result.right_long_clip = upd.recent_clip_long;
        end
        state_next = is_last ? parse_state_t'('0) : upd;
        emit       = result.op_valid || is_last;
    end

endmodule

[rtl/core/csp_checker.sv]
// Port-level checks for the CIGAR string parser, bound to the top level.
// Depends on csp_pkg for the operation codes.
module csp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          op_valid,
    input logic [csp_pkg::CODE_W-1:0]    op_code,
    input logic [csp_pkg::COUNT_W-1:0]   op_length,
    input logic                          string_done,
    input logic [csp_pkg::COVER_W-1:0]   covered_length,
    input logic                          left_long_clip,
    input logic                          right_long_clip
);
    import csp_pkg::*;

    // A stalled result beat holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(op_code)
            && $stable(op_length) && $stable(covered_length))
        else $error("result beat changed while stalled");

    // A beat without an operation only appears at the end of a string.
    a_no_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !op_valid |-> string_done && op_code == OP_M && op_length == '0)
        else $error("result beat carries neither an operation nor an end");

    // Summary fields are zero except on the end-of-string beat.
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !string_done |->
            covered_length == '0 && !left_long_clip && !right_long_clip)
        else $error("summary fields set before the end of a string");

    // Operation codes stay within the BAM set.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_valid |-> op_code <= OP_X)
        else $error("operation code out of range");

    // The input side only stalls while a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind cigar_string_parser_top csp_checker u_csp_checker (.*);
